/* design/particle_pool_engine_top_macros.svh */
// Assertion macros shared by the particle pool engine RTL.
// Every macro samples on clk and is disabled while rst is high.
`ifndef PARTICLE_POOL_ENGINE_TOP_MACROS_SVH
`define PARTICLE_POOL_ENGINE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/ppe_pkg.sv */
// Package for the particle pool engine: sequencer states, codes and constants.
// It has no dependencies. It is used by the top level and by the multiplier unit.
`default_nettype none

package ppe_pkg;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_A_MUL,
    S_A_ACC,
    S_A_WR,
    S_T_DEC0,
    S_T_DEC1,
    S_T_RD,
    S_T_LOAD,
    S_T_MUL,
    S_T_ACC,
    S_T_DEC,
    S_T_WR,
    S_R_RD,
    S_R_OUT,
    S_FINISH
  } state_t;

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [1:0] CFG_VSCALE = 2'd0;
  localparam logic [1:0] CFG_DECAY  = 2'd1;

  localparam logic [16:0] VSCALE_RESET = 17'd19661;
  localparam logic [16:0] DECAY_RESET  = 17'd3277;

  localparam logic [19:0] LIFE_START      = 20'd655360;
  localparam logic [16:0] INTENSITY_START = 17'd65536;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 21;
  localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;

  // Saturates a 40-bit signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/ppe_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; contents are undefined until written.
`default_nettype none

module ppe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/ppe_mul.sv */
// Shared signed-by-unsigned multiplier of the particle pool engine.
// Depends on ppe_pkg for operand widths; the product is registered.
`default_nettype none

module ppe_mul import ppe_pkg::*; (
  input  wire                        clk,
  input  wire signed [MUL_A_W-1:0]   a,
  input  wire        [MUL_B_W-1:0]   b,
  output logic signed [PROD_W-1:0]   prod
);

  always_ff @(posedge clk) begin
    prod <= a * $signed({1'b0, b});
  end

endmodule

`default_nettype wire

/* design/particle_pool_engine_top.sv */
// Particle pool engine top level: sequencer, slot stores and result register.
// Depends on ppe_pkg, ppe_ram, ppe_mul and particle_pool_engine_top_macros.svh.
// After reset the stores are cleared, one slot per cycle; no request is taken
// then. An add searches the slots for a free one, starting at the last slot
// written; a tick reads and writes back every slot; a read fetches one slot.
// One request at a time goes through the shared multiplier.
`default_nettype none
`include "particle_pool_engine_top_macros.svh"

module particle_pool_engine_top import ppe_pkg::*; #(
  parameter int POOL_SIZE = 64
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire [1:0]          cfg_index,
  input  wire [16:0]         cfg_data,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire [1:0]          operation,
  input  wire signed [31:0]  pos_x,
  input  wire signed [31:0]  pos_y,
  input  wire signed [31:0]  pos_z,
  input  wire signed [31:0]  vel_x,
  input  wire signed [31:0]  vel_y,
  input  wire signed [31:0]  vel_z,
  input  wire [19:0]         delta_time,
  input  wire [5:0]          read_slot,
  output logic               out_valid,
  input  wire                out_ready,
  output logic [5:0]         slot_index,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [16:0]        brightness,
  output logic               alive
);

  localparam int IDX_W = $clog2(POOL_SIZE);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SIZE - 1);

  state_t state, state_next;

  logic [16:0] velocity_scale, decay_rate;

  logic [IDX_W-1:0] idx, cnt, last_slot;
  logic [1:0]       k;
  logic [1:0]       op;
  logic signed [31:0] pin [3];
  logic signed [31:0] vin [3];
  logic [19:0]      dt;
  logic [5:0]       rs;

  logic [19:0]        wlife;
  logic [16:0]        wint;
  logic signed [31:0] wpos [3];
  logic signed [31:0] wvel [3];
  logic [20:0]        dec;

  logic [5:0]         r_slot;
  logic signed [31:0] r_x, r_y, r_z;
  logic [16:0]        r_bri;
  logic               r_alive;

  // Store ports
  logic             we;
  logic [IDX_W-1:0] addr;
  logic [19:0]      life_wdata, life_rd;
  logic [16:0]      int_wdata, int_rd;
  logic [95:0]      pos_wdata, pos_rd;
  logic [95:0]      vel_wdata, vel_rd;

  // Multiplier unit
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [38:0]        step;

  logic [IDX_W-1:0] idx_inc, last_inc;
  logic [31:0]      rs_ext, idx_ext;
  logic [IDX_W-1:0] rs_idx;
  logic             rs_in_range;
  logic             finish_take;

  assign idx_inc     = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  assign last_inc    = (last_slot == LAST_IDX) ? '0 : last_slot + 1'b1;
  assign rs_ext      = {26'd0, rs};
  assign rs_idx      = rs_ext[IDX_W-1:0];
  assign rs_in_range = rs_ext < 32'(POOL_SIZE);
  assign idx_ext     = 32'(idx);
  assign step        = prod[54:16];
  assign finish_take = (state == S_FINISH) && (!out_valid || out_ready);
  assign cfg_ready   = 1'b1;

  ppe_ram #(.WIDTH(20), .DEPTH(POOL_SIZE)) u_life (
    .clk(clk), .we(we), .waddr(addr), .wdata(life_wdata), .raddr(addr), .rdata(life_rd)
  );
  ppe_ram #(.WIDTH(17), .DEPTH(POOL_SIZE)) u_intensity (
    .clk(clk), .we(we), .waddr(addr), .wdata(int_wdata), .raddr(addr), .rdata(int_rd)
  );
  ppe_ram #(.WIDTH(96), .DEPTH(POOL_SIZE)) u_position (
    .clk(clk), .we(we), .waddr(addr), .wdata(pos_wdata), .raddr(addr), .rdata(pos_rd)
  );
  ppe_ram #(.WIDTH(96), .DEPTH(POOL_SIZE)) u_velocity (
    .clk(clk), .we(we), .waddr(addr), .wdata(vel_wdata), .raddr(addr), .rdata(vel_rd)
  );

  ppe_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (idx == LAST_IDX) state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          case (operation)
            OP_ADD:  state_next = S_A_RD;
            OP_TICK: state_next = S_T_DEC0;
            OP_READ: state_next = S_R_RD;
            default: state_next = S_FINISH;
          endcase
        end
      end
      S_A_RD:   state_next = S_A_CHK;
      S_A_CHK: begin
        if (life_rd == '0 || cnt == LAST_IDX) begin
          state_next = S_A_MUL;
        end else begin
          state_next = S_A_RD;
        end
      end
      S_A_MUL:  state_next = S_A_ACC;
      S_A_ACC:  state_next = (k == 2'd2) ? S_A_WR : S_A_MUL;
      S_A_WR:   state_next = S_FINISH;
      S_T_DEC0: state_next = S_T_DEC1;
      S_T_DEC1: state_next = S_T_RD;
      S_T_RD:   state_next = S_T_LOAD;
      S_T_LOAD: state_next = S_T_MUL;
      S_T_MUL:  state_next = (wlife == '0) ? S_T_WR : S_T_ACC;
      S_T_ACC:  state_next = (k == 2'd2) ? S_T_DEC : S_T_MUL;
      S_T_DEC:  state_next = S_T_WR;
      S_T_WR:   state_next = (idx == LAST_IDX) ? S_FINISH : S_T_RD;
      S_R_RD:   state_next = rs_in_range ? S_R_OUT : S_FINISH;
      S_R_OUT:  state_next = S_FINISH;
      S_FINISH: if (!out_valid || out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Store, multiplier and handshake controls
  always_comb begin
    in_ready   = (state == S_IDLE);
    we         = 1'b0;
    addr       = idx;
    life_wdata = '0;
    int_wdata  = '0;
    pos_wdata  = '0;
    vel_wdata  = '0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      S_CLEAR: we = 1'b1;
      S_A_MUL: begin
        mul_a = MUL_A_W'(vin[k]);
        mul_b = MUL_B_W'(velocity_scale);
      end
      S_A_WR: begin
        we         = 1'b1;
        life_wdata = LIFE_START;
        int_wdata  = INTENSITY_START;
        pos_wdata  = {pin[2], pin[1], pin[0]};
        vel_wdata  = {wvel[2], wvel[1], wvel[0]};
      end
      S_T_DEC0: begin
        mul_a = $signed(MUL_A_W'(decay_rate));
        mul_b = MUL_B_W'(dt);
      end
      S_T_MUL: begin
        mul_a = MUL_A_W'(wvel[k]);
        mul_b = MUL_B_W'(dt);
      end
      S_T_WR: begin
        we         = 1'b1;
        life_wdata = wlife;
        int_wdata  = wint;
        pos_wdata  = {wpos[2], wpos[1], wpos[0]};
        vel_wdata  = {wvel[2], wvel[1], wvel[0]};
      end
      S_R_RD: addr = rs_idx;
      default: ;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      velocity_scale <= VSCALE_RESET;
      decay_rate     <= DECAY_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_VSCALE) velocity_scale <= cfg_data;
      if (cfg_index == CFG_DECAY)  decay_rate     <= cfg_data;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      idx       <= '0;
      cnt       <= '0;
      k         <= '0;
      last_slot <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish_take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: idx <= idx_inc;
        S_IDLE: begin
          idx <= (operation == OP_ADD) ? last_slot : '0;
          cnt <= '0;
          k   <= '0;
        end
        S_A_CHK: begin
          k <= '0;
          if (life_rd != '0) begin
            if (cnt == LAST_IDX) begin
              idx <= last_inc;
            end else begin
              idx <= idx_inc;
              cnt <= cnt + 1'b1;
            end
          end
        end
        S_A_ACC:  k <= k + 1'b1;
        S_A_WR:   last_slot <= idx;
        S_T_LOAD: k <= '0;
        S_T_ACC:  k <= k + 1'b1;
        S_T_WR:   idx <= idx_inc;
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op      <= operation;
        pin[0]  <= pos_x;
        pin[1]  <= pos_y;
        pin[2]  <= pos_z;
        vin[0]  <= vel_x;
        vin[1]  <= vel_y;
        vin[2]  <= vel_z;
        dt      <= delta_time;
        rs      <= read_slot;
        r_slot  <= (operation == OP_READ) ? read_slot : 6'd0;
        r_x     <= '0;
        r_y     <= '0;
        r_z     <= '0;
        r_bri   <= '0;
        r_alive <= 1'b0;
      end
      S_A_ACC: wvel[k] <= sat32(40'(step));
      S_A_WR: begin
        r_slot  <= idx_ext[5:0];
        r_alive <= 1'b1;
      end
      S_T_DEC1: dec <= prod[36:16];
      S_T_LOAD: begin
        wlife   <= (life_rd > dt) ? life_rd - dt : '0;
        wint    <= int_rd;
        wpos[0] <= pos_rd[31:0];
        wpos[1] <= pos_rd[63:32];
        wpos[2] <= pos_rd[95:64];
        wvel[0] <= vel_rd[31:0];
        wvel[1] <= vel_rd[63:32];
        wvel[2] <= vel_rd[95:64];
      end
      S_T_ACC: wpos[k] <= sat32(40'(wpos[k]) + 40'(step));
      S_T_DEC: begin
        // Only a decay larger than the intensity kills; reaching zero does not.
        if (dec > 21'(wint)) begin
          wint  <= '0;
          wlife <= '0;
        end else begin
          wint <= wint - dec[16:0];
        end
      end
      S_R_OUT: begin
        r_x     <= pos_rd[31:0];
        r_y     <= pos_rd[63:32];
        r_z     <= pos_rd[95:64];
        r_bri   <= int_rd;
        r_alive <= (life_rd != '0);
      end
      default: ;
    endcase
    if (finish_take) begin
      slot_index <= r_slot;
      out_x      <= r_x;
      out_y      <= r_y;
      out_z      <= r_z;
      brightness <= r_bri;
      alive      <= r_alive;
    end
  end

  `PPE_ASSERT_NOW(a_no_request_in_clear, state == S_CLEAR, !in_ready, "request taken during clear")
  `PPE_ASSERT_NOW(a_add_alive, state == S_FINISH && op == OP_ADD, r_alive, "add result not alive")
  `PPE_ASSERT_NOW(a_life_bound, we, life_wdata <= LIFE_START, "life above start value")
  `PPE_ASSERT_NOW(a_int_bound, we, int_wdata <= INTENSITY_START, "intensity above start value")
  `PPE_ASSERT_NEXT(a_finish_sets_out, finish_take, out_valid, "result not presented")

endmodule

`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for particle_pool_engine_top: random and directed requests
// are checked against a cycle-free model of the particle pool. Depends on ppe_pkg.
`timescale 1ns / 1ps

module tb;
  import ppe_pkg::*;

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] px, py, pz, vx, vy, vz;
    logic [19:0]        dt;
    logic [5:0]         rs;
  } request_t;

  typedef struct {
    logic [5:0]         slot;
    logic signed [31:0] x, y, z;
    logic [16:0]        glow;
    logic               alive;
  } particle_view_t;

  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = CFG_VSCALE;
  logic [16:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] operation = OP_ADD;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [31:0] vel_x = '0, vel_y = '0, vel_z = '0;
  logic [19:0] delta_time = '0;
  logic [5:0] read_slot = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [5:0] slot_index;
  logic signed [31:0] out_x, out_y, out_z;
  logic [16:0] brightness;
  logic alive;

  particle_pool_engine_top dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
    .delta_time(delta_time), .read_slot(read_slot),
    .out_valid(out_valid), .out_ready(out_ready), .slot_index(slot_index),
    .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .brightness(brightness), .alive(alive)
  );

  // Model of the pool.
  logic [19:0]        life_tab[64];
  logic [16:0]        glow_tab[64];
  logic signed [31:0] pos_tab[64][3];
  logic signed [31:0] vel_tab[64][3];
  logic [5:0]         last_used;
  logic [16:0]        vscale_cfg = VSCALE_RESET;
  logic [16:0]        decay_cfg = DECAY_RESET;

  request_t       pending_requests[$];
  particle_view_t expected_views[$];
  request_t       cur_request;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  mismatches = 0;
  int  requests_sent = 0;
  int  views_checked = 0;
  int  hold_left = 0;
  logic hold_trigger = 1'b0;
  int  quiet_cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic void reset_pool();
    for (int i = 0; i < 64; i++) begin
      life_tab[i] = '0;
      glow_tab[i] = '0;
      for (int k = 0; k < 3; k++) begin
        pos_tab[i][k] = '0;
        vel_tab[i][k] = '0;
      end
    end
    last_used = '0;
  endfunction

  // Applies one request to the pool model and returns the view it reports.
  function automatic particle_view_t update_pool(input request_t r);
    particle_view_t v;
    logic [5:0] j;
    logic found;
    logic signed [63:0] wide, scale;
    logic [63:0] dec;
    logic signed [31:0] vin[3];
    logic signed [31:0] pin[3];
    v = '{slot: '0, x: '0, y: '0, z: '0, glow: '0, alive: 1'b0};
    case (r.op)
      OP_ADD: begin
        j = last_used;
        found = 1'b0;
        for (int i = 0; i < 64; i++) begin
          if (!found) begin
            if (life_tab[j] == 0) found = 1'b1;
            else j = j + 6'd1;
          end
        end
        if (!found) j = last_used + 6'd1;
        last_used = j;
        pin = '{r.px, r.py, r.pz};
        vin = '{r.vx, r.vy, r.vz};
        scale = {47'd0, vscale_cfg};
        for (int k = 0; k < 3; k++) begin
          pos_tab[j][k] = pin[k];
          wide = vin[k];
          vel_tab[j][k] = clamp32((wide * scale) >>> 16);
        end
        life_tab[j] = LIFE_START;
        glow_tab[j] = INTENSITY_START;
        v.slot = j;
        v.alive = 1'b1;
      end
      OP_TICK: begin
        dec = (64'(decay_cfg) * 64'(r.dt)) >> 16;
        for (int i = 0; i < 64; i++) begin
          life_tab[i] = (life_tab[i] > r.dt) ? life_tab[i] - r.dt : 20'd0;
          if (life_tab[i] != 0) begin
            for (int k = 0; k < 3; k++) begin
              wide = vel_tab[i][k];
              wide = (wide * $signed({44'd0, r.dt})) >>> 16;
              pos_tab[i][k] = clamp32(64'(pos_tab[i][k]) + wide);
            end
            // Reaching exactly zero leaves the particle alive.
            if (dec > 64'(glow_tab[i])) begin
              glow_tab[i] = '0;
              life_tab[i] = '0;
            end else begin
              glow_tab[i] = glow_tab[i] - dec[16:0];
            end
          end
        end
      end
      OP_READ: begin
        v.slot = r.rs;
        v.x = pos_tab[r.rs][0];
        v.y = pos_tab[r.rs][1];
        v.z = pos_tab[r.rs][2];
        v.glow = glow_tab[r.rs];
        v.alive = life_tab[r.rs] != 0;
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(9))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2, 3, 4: return $signed(32'($urandom_range(0, 1 << 20))) - 32'sd524288;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_request(input logic [1:0] op, input logic [19:0] dt,
                               input logic [5:0] rs);
    request_t r;
    r = '{op: op, px: pick_coord(), py: pick_coord(), pz: pick_coord(),
          vx: pick_coord(), vy: pick_coord(), vz: pick_coord(), dt: dt, rs: rs};
    pending_requests.push_back(r);
  endtask

  task automatic queue_random(input int count);
    int sel;
    logic [19:0] dt;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      case ($urandom_range(9))
        0: dt = 20'hFFFFF;
        1: dt = 20'd65536;
        2, 3: dt = 20'($urandom);
        default: dt = 20'($urandom_range(0, 4096));
      endcase
      if (sel < 45) queue_request(OP_ADD, 20'($urandom), 6'($urandom));
      else if (sel < 62) queue_request(OP_TICK, dt, 6'($urandom));
      else if (sel < 95) queue_request(OP_READ, 20'($urandom), 6'($urandom));
      else queue_request(OP_NOP, 20'($urandom), 6'($urandom));
    end
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [16:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_VSCALE) vscale_cfg = value;
    else decay_cfg = value;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_views.size() != 0);
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (!rst && (!in_valid || in_ready)) begin
      if (in_valid) begin
        expected_views.push_back(update_pool(cur_request));
        requests_sent++;
      end
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_request = pending_requests.pop_front();
        in_valid <= 1'b1;
        operation <= cur_request.op;
        pos_x <= cur_request.px;
        pos_y <= cur_request.py;
        pos_z <= cur_request.pz;
        vel_x <= cur_request.vx;
        vel_y <= cur_request.vy;
        vel_z <= cur_request.vz;
        delta_time <= cur_request.dt;
        read_slot <= cur_request.rs;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here.
  always @(posedge clk) begin
    if (hold_trigger && hold_left == 0) hold_left <= 3000;
    else if (hold_left > 1) hold_left <= hold_left - 1;
  end

  // Result monitor.
  always @(posedge clk) begin
    particle_view_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_views.size() == 0) begin
          $error("unexpected result, slot_index %0d", slot_index);
          mismatches++;
        end else begin
          e = expected_views.pop_front();
          views_checked++;
          if (slot_index !== e.slot) begin
            $error("slot_index: expected %0d, got %0d", e.slot, slot_index);
            mismatches++;
          end
          if (out_x !== e.x) begin
            $error("out_x: expected %0d, got %0d", e.x, out_x);
            mismatches++;
          end
          if (out_y !== e.y) begin
            $error("out_y: expected %0d, got %0d", e.y, out_y);
            mismatches++;
          end
          if (out_z !== e.z) begin
            $error("out_z: expected %0d, got %0d", e.z, out_z);
            mismatches++;
          end
          if (brightness !== e.glow) begin
            $error("brightness: expected %0d, got %0d", e.glow, brightness);
            mismatches++;
          end
          if (alive !== e.alive) begin
            $error("alive: expected %0d, got %0d", e.alive, alive);
            mismatches++;
          end
        end
      end
      out_ready <= (hold_left <= 1 || !hold_trigger) && $urandom_range(99) >= recv_stall_pct;
    end
  end

  // Watchdog on cycles in which no request moves while work is outstanding.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) ||
        (!in_valid && expected_views.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [16:0] vs_set[6];
    logic [16:0] dr_set[6];
    int send_set[6];
    int recv_set[6];
    reset_pool();
    vs_set = '{VSCALE_RESET, 17'd0, 17'd65536, 17'd1, 17'd0, VSCALE_RESET};
    dr_set = '{DECAY_RESET, 17'd0, 17'd65536, 17'd1, 17'd0, DECAY_RESET};
    send_set = '{0, 80, 0, 25, 0, 80};
    recv_set = '{0, 0, 80, 25, 0, 0};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, every operation, zero and full-scale ticks.
    pending_requests.push_back('{OP_ADD, 32'sh7FFFFFFF, 32'sh80000000, 32'sd0,
                                 32'sh7FFFFFFF, 32'sh80000000, -32'sd1, 20'd0, 6'd0});
    pending_requests.push_back('{OP_ADD, 32'sh80000000, 32'sh7FFFFFFF, -32'sd1,
                                 32'sh80000000, 32'sh7FFFFFFF, 32'sd1, 20'hFFFFF, 6'd63});
    pending_requests.push_back('{OP_READ, '0, '0, '0, '0, '0, '0, 20'd0, 6'd0});
    pending_requests.push_back('{OP_READ, '0, '0, '0, '0, '0, '0, 20'd0, 6'd1});
    pending_requests.push_back('{OP_TICK, '0, '0, '0, '0, '0, '0, 20'd0, 6'd0});
    pending_requests.push_back('{OP_TICK, '0, '0, '0, '0, '0, '0, 20'd65536, 6'd0});
    pending_requests.push_back('{OP_READ, '0, '0, '0, '0, '0, '0, 20'd0, 6'd0});
    pending_requests.push_back('{OP_READ, '0, '0, '0, '0, '0, '0, 20'd0, 6'd1});
    pending_requests.push_back('{OP_NOP, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1,
                                 -32'sd1, 20'hFFFFF, 6'd63});
    queue_request(OP_ADD, 20'd0, 6'd0);
    pending_requests.push_back('{OP_TICK, '0, '0, '0, '0, '0, '0, 20'hFFFFF, 6'd0});
    for (int s = 0; s < 3; s++) queue_request(OP_READ, 20'd0, 6'(s));
    queue_request(OP_READ, 20'd0, 6'd63);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      write_register(CFG_VSCALE, p == 4 ? 17'($urandom_range(0, 65536)) : vs_set[p]);
      write_register(CFG_DECAY, p == 4 ? 17'($urandom_range(0, 65536)) : dr_set[p]);
      send_idle_pct = send_set[p];
      recv_stall_pct = recv_set[p];
      // With full decay a one-second tick lands intensity exactly on zero.
      if (p == 2) begin
        queue_request(OP_ADD, 20'd0, 6'd0);
        queue_request(OP_TICK, 20'd65536, 6'd0);
        for (int s = 0; s < 4; s++) queue_request(OP_READ, 20'd0, 6'(s));
      end
      queue_random(255);
      if (p == 0) begin
        hold_trigger = 1'b1;
        repeat (3100) @(posedge clk);
        hold_trigger = 1'b0;
      end
      wait_drained();
    end

    repeat (700) @(posedge clk);
    $display("Sent %0d requests over six register settings and idling mixes;", requests_sent);
    $display("checked %0d results with %0d mismatching fields.", views_checked, mismatches);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/ppe_pkg.sv
design/ppe_ram.sv
design/ppe_mul.sv
design/particle_pool_engine_top.sv
sim/tb.sv
